// ===== hdl/fpc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and binary64 helper functions for the affine clamp.
// Used by every module of the block; depends on nothing.
package fpc_pkg;

    localparam int LATENCY = 16;
    localparam logic [63:0] QNAN = 64'h7FF8000000000000;
    localparam logic [10:0] EXP_ONES = 11'h7FF;

    // Register indexes of the configuration port
    typedef enum logic [1:0] {
        REG_SCALE  = 2'd0,
        REG_OFFSET = 2'd1,
        REG_LOWER  = 2'd2,
        REG_UPPER  = 2'd3
    } cfg_reg_t;

    typedef logic signed [13:0] exp_t;

    // Unrounded value: sig[55] is the leading bit, sig[2:1] guard and round,
    // sig[0] sticky; e is the biased exponent
    typedef struct packed {
        logic        sign;
        exp_t        e;
        logic [55:0] sig;
    } rnd_t;

    // Special-case flags that ride along with an operation
    typedef struct packed {
        logic nan;
        logic inf;
        logic zero;
        logic sign;
    } spec_t;

    function automatic logic is_nan(input logic [63:0] b);
        return (b[62:52] == EXP_ONES) && (b[51:0] != 52'd0);
    endfunction

    // Count leading zeros, 64 when the word is zero
    function automatic logic [6:0] lzc64(input logic [63:0] v);
        logic [6:0] cnt;
        cnt = 7'd64;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) cnt = 7'(63 - i);
        end
        return cnt;
    endfunction

    // Shift a value whose exponent is below the normal range into subnormal form
    function automatic rnd_t denorm(input rnd_t r);
        rnd_t        o;
        exp_t        sh;
        logic [5:0]  sh6;
        logic [63:0] w;
        logic [63:0] mask;
        logic        st;
        o = r;
        if (r.e < 14'sd1) begin
            sh = 14'sd1 - r.e;
            if (sh > 14'sd63) sh6 = 6'd63;
            else sh6 = sh[5:0];
            w = {8'd0, r.sig};
            mask = (64'd1 << sh6) - 64'd1;
            st = |(w & mask);
            w = w >> sh6;
            o.sig = {w[55:1], w[0] | st};
            o.e = 14'sd0;
        end
        return o;
    endfunction

    // Round to nearest even and pack; carry out of the fraction bumps the exponent
    function automatic logic [63:0] round_pack(input rnd_t r);
        logic [62:0] base;
        logic        up;
        logic [62:0] sum;
        if (r.e >= 14'sd2047) begin
            return {r.sign, EXP_ONES, 52'd0};
        end
        base = {r.e[10:0], r.sig[54:3]};
        up = r.sig[2] & ((|r.sig[1:0]) | r.sig[3]);
        sum = base + {62'd0, up};
        return {r.sign, sum};
    endfunction

endpackage

// ===== hdl/fp64_affine_clamp.sv =====
`timescale 1ns / 1ps
// Pipeline of 7 multiply stages, 7 add stages and 2 clamp stages from start to
// the done strobe. Throughput: one item per cycle, busy stays low.
// The receiver cannot stall; done pulses for one cycle with each result.
// Reset (rst_n low, asynchronous) empties the pipeline and restores scale 1.0,
// offset +0.0, lower bound -inf, upper bound +inf. Depends on fpc_pkg.
module fp64_affine_clamp
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] sample_bits,
    input  logic        last_in,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output logic        done,
    output logic [63:0] result_bits,
    output logic        last_out
);

    logic [63:0] scale_bits_reg;
    logic [63:0] offset_bits_reg;
    logic [63:0] lower_bound_bits_reg;
    logic [63:0] upper_bound_bits_reg;
    logic        accept;
    logic        mul_valid, mul_last;
    logic [63:0] mul_bits;
    logic        add_valid, add_last;
    logic [63:0] add_bits;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start & ~busy;

    // Write the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            scale_bits_reg       <= 64'h3FF0000000000000;
            offset_bits_reg      <= 64'h0000000000000000;
            lower_bound_bits_reg <= 64'hFFF0000000000000;
            upper_bound_bits_reg <= 64'h7FF0000000000000;
        end
        else if (cfg_valid && cfg_ready) begin
            case (fpc_pkg::cfg_reg_t'(cfg_index))
                fpc_pkg::REG_SCALE:  scale_bits_reg       <= cfg_data;
                fpc_pkg::REG_OFFSET: offset_bits_reg      <= cfg_data;
                fpc_pkg::REG_LOWER:  lower_bound_bits_reg <= cfg_data;
                fpc_pkg::REG_UPPER:  upper_bound_bits_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    fpc_mul u_mul
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (accept),
        .last_in   (last_in),
        .a         (sample_bits),
        .b         (scale_bits_reg),
        .valid_out (mul_valid),
        .last_out  (mul_last),
        .prod_bits (mul_bits)
    );

    fpc_add u_add
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (mul_valid),
        .last_in   (mul_last),
        .a         (mul_bits),
        .b         (offset_bits_reg),
        .valid_out (add_valid),
        .last_out  (add_last),
        .sum_bits  (add_bits)
    );

    fpc_clamp u_clamp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (add_valid),
        .last_in   (add_last),
        .val       (add_bits),
        .lower     (lower_bound_bits_reg),
        .upper     (upper_bound_bits_reg),
        .valid_out (done),
        .last_out  (last_out),
        .result    (result_bits)
    );

endmodule

// ===== hdl/fpc_mul.sv =====
`timescale 1ns / 1ps
// Seven-stage binary64 multiplier, round to nearest even.
// Depends on fpc_pkg for the rounding helpers and stage types.
module fpc_mul
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid_in,
    input  logic        last_in,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        valid_out,
    output logic        last_out,
    output logic [63:0] prod_bits
);

    logic [6:0]        v_reg;
    logic [6:0]        l_reg;
    fpc_pkg::spec_t    sp_reg [6:0];

    // stage 1: unpack
    logic [52:0]       ma1_reg, mb1_reg;
    fpc_pkg::exp_t     ea1_reg, eb1_reg;
    logic [6:0]        lza1_reg, lzb1_reg;
    logic [52:0]       ma1_next, mb1_next;
    fpc_pkg::exp_t     ea1_next, eb1_next;
    fpc_pkg::spec_t    sp_next;
    // stage 2: normalize
    logic [52:0]       ma2_reg, mb2_reg;
    fpc_pkg::exp_t     ea2_reg, eb2_reg;
    // stage 3: partial products
    logic [53:0]       pp0_reg;
    logic [52:0]       pp1_reg, pp2_reg;
    logic [51:0]       pp3_reg;
    fpc_pkg::exp_t     es3_reg;
    // stage 4: product
    logic [105:0]      prod4_reg;
    logic [53:0]       mid;
    fpc_pkg::exp_t     es4_reg;
    // stages 5..7
    fpc_pkg::rnd_t     r5_reg, r5_next, r6_reg;
    logic [63:0]       out7_reg, out7_next;

    // Unpack operands and flag the special cases
    always_comb
    begin
        logic na, nb, ia, ib, za, zb;
        na = fpc_pkg::is_nan(a);
        nb = fpc_pkg::is_nan(b);
        ia = (a[62:52] == fpc_pkg::EXP_ONES) && (a[51:0] == 52'd0);
        ib = (b[62:52] == fpc_pkg::EXP_ONES) && (b[51:0] == 52'd0);
        za = (a[62:0] == 63'd0);
        zb = (b[62:0] == 63'd0);
        ma1_next = {|a[62:52], a[51:0]};
        mb1_next = {|b[62:52], b[51:0]};
        ea1_next = (a[62:52] == 11'd0) ? 14'sd1 : fpc_pkg::exp_t'({3'd0, a[62:52]});
        eb1_next = (b[62:52] == 11'd0) ? 14'sd1 : fpc_pkg::exp_t'({3'd0, b[62:52]});
        sp_next.nan  = na | nb | (ia & zb) | (za & ib);
        sp_next.inf  = ia | ib;
        sp_next.zero = za | zb;
        sp_next.sign = a[63] ^ b[63];
    end

    assign mid = 54'(pp1_reg) + 54'(pp2_reg);

    // Pick the leading bit of the product and fold the tail into sticky
    always_comb
    begin
        r5_next.sign = sp_reg[3].sign;
        if (prod4_reg[105]) begin
            r5_next.e   = es4_reg + 14'sd1;
            r5_next.sig = {prod4_reg[105:51], |prod4_reg[50:0]};
        end
        else begin
            r5_next.e   = es4_reg;
            r5_next.sig = {prod4_reg[104:50], |prod4_reg[49:0]};
        end
    end

    // Round and substitute special results
    always_comb
    begin
        if (sp_reg[5].nan) out7_next = fpc_pkg::QNAN;
        else if (sp_reg[5].inf) out7_next = {sp_reg[5].sign, fpc_pkg::EXP_ONES, 52'd0};
        else if (sp_reg[5].zero) out7_next = {sp_reg[5].sign, 63'd0};
        else out7_next = fpc_pkg::round_pack(r6_reg);
    end

    // Advance the valid and last bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v_reg <= '0;
            l_reg <= '0;
        end
        else begin
            v_reg <= {v_reg[5:0], valid_in};
            l_reg <= {l_reg[5:0], last_in};
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        sp_reg[0] <= sp_next;
        for (int i = 1; i < 7; i++) begin
            sp_reg[i] <= sp_reg[i-1];
        end
        ma1_reg  <= ma1_next;
        mb1_reg  <= mb1_next;
        ea1_reg  <= ea1_next;
        eb1_reg  <= eb1_next;
        lza1_reg <= fpc_pkg::lzc64({ma1_next, 11'd0});
        lzb1_reg <= fpc_pkg::lzc64({mb1_next, 11'd0});
        ma2_reg  <= ma1_reg << lza1_reg[5:0];
        mb2_reg  <= mb1_reg << lzb1_reg[5:0];
        ea2_reg  <= ea1_reg - fpc_pkg::exp_t'({7'd0, lza1_reg});
        eb2_reg  <= eb1_reg - fpc_pkg::exp_t'({7'd0, lzb1_reg});
        pp0_reg  <= 54'(ma2_reg[26:0]) * 54'(mb2_reg[26:0]);
        pp1_reg  <= 53'(ma2_reg[26:0]) * 53'(mb2_reg[52:27]);
        pp2_reg  <= 53'(ma2_reg[52:27]) * 53'(mb2_reg[26:0]);
        pp3_reg  <= 52'(ma2_reg[52:27]) * 52'(mb2_reg[52:27]);
        es3_reg  <= ea2_reg + eb2_reg - 14'sd1023;
        prod4_reg <= 106'(pp0_reg) + (106'(mid) << 27) + (106'(pp3_reg) << 54);
        es4_reg  <= es3_reg;
        r5_reg   <= r5_next;
        r6_reg   <= fpc_pkg::denorm(r5_reg);
        out7_reg <= out7_next;
    end

    assign valid_out = v_reg[6];
    assign last_out  = l_reg[6];
    assign prod_bits = out7_reg;

endmodule

// ===== hdl/fpc_add.sv =====
`timescale 1ns / 1ps
// Seven-stage binary64 adder, round to nearest even.
// Depends on fpc_pkg for the rounding helpers and stage types.
module fpc_add
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid_in,
    input  logic        last_in,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        valid_out,
    output logic        last_out,
    output logic [63:0] sum_bits
);

    logic [6:0]        v_reg;
    logic [6:0]        l_reg;
    fpc_pkg::spec_t    sp_reg [6:0];
    logic [6:0]        zs_reg;
    logic [6:0]        sub_reg;
    fpc_pkg::exp_t     be_reg [4:0];

    fpc_pkg::spec_t    sp_next;
    logic              zs_next;
    logic              sub_next;
    fpc_pkg::exp_t     be_next;
    logic [52:0]       bm_next, sm_next;
    logic [10:0]       d_next;

    logic [52:0]       bm1_reg, sm1_reg;
    logic [10:0]       d1_reg;
    logic [55:0]       big2_reg, sml2_reg, sml2_next;
    logic [56:0]       s3_reg;
    logic [56:0]       s4_reg;
    logic [6:0]        lz4_reg;
    fpc_pkg::rnd_t     r5_reg, r5_next, r6_reg;
    logic              z5_reg, z6_reg;
    logic [63:0]       out7_reg, out7_next;

    // Unpack, order by magnitude and flag the special cases
    always_comb
    begin
        logic        na, nb, ia, ib, a_big;
        logic [63:0] bg, sm;
        logic [10:0] bge, sme;
        na = fpc_pkg::is_nan(a);
        nb = fpc_pkg::is_nan(b);
        ia = (a[62:52] == fpc_pkg::EXP_ONES) && (a[51:0] == 52'd0);
        ib = (b[62:52] == fpc_pkg::EXP_ONES) && (b[51:0] == 52'd0);
        a_big = (a[62:0] >= b[62:0]);
        bg = a_big ? a : b;
        sm = a_big ? b : a;
        bge = (bg[62:52] == 11'd0) ? 11'd1 : bg[62:52];
        sme = (sm[62:52] == 11'd0) ? 11'd1 : sm[62:52];
        bm_next = {|bg[62:52], bg[51:0]};
        sm_next = {|sm[62:52], sm[51:0]};
        d_next  = bge - sme;
        be_next = fpc_pkg::exp_t'({3'd0, bge});
        sub_next = a[63] ^ b[63];
        zs_next  = a[63] & b[63];
        sp_next.nan  = na | nb | (ia & ib & (a[63] != b[63]));
        sp_next.inf  = ia | ib;
        sp_next.zero = 1'b0;
        sp_next.sign = ia ? a[63] : (ib ? b[63] : bg[63]);
    end

    // Align the smaller operand, keep the lost bits as sticky
    always_comb
    begin
        logic [63:0] w, mask;
        logic [5:0]  sh6;
        logic        st;
        sh6 = (d1_reg > 11'd63) ? 6'd63 : d1_reg[5:0];
        w = {5'd0, sm1_reg, 3'd0, 3'd0};
        w = w >> 3;
        mask = (64'd1 << sh6) - 64'd1;
        st = |(w & mask);
        w = w >> sh6;
        sml2_next = {w[55:1], w[0] | st};
    end

    // Normalize after the add
    always_comb
    begin
        r5_next.sign = sp_reg[3].sign;
        if (s4_reg[56]) begin
            r5_next.e   = be_reg[3] + 14'sd1;
            r5_next.sig = {s4_reg[56:2], s4_reg[1] | s4_reg[0]};
        end
        else begin
            r5_next.e   = be_reg[3] - fpc_pkg::exp_t'({7'd0, lz4_reg});
            r5_next.sig = s4_reg[55:0] << lz4_reg[5:0];
        end
    end

    // Round and substitute special results
    always_comb
    begin
        if (sp_reg[5].nan) out7_next = fpc_pkg::QNAN;
        else if (sp_reg[5].inf) out7_next = {sp_reg[5].sign, fpc_pkg::EXP_ONES, 52'd0};
        else if (z6_reg) out7_next = {zs_reg[5], 63'd0};
        else out7_next = fpc_pkg::round_pack(r6_reg);
    end

    // Advance the valid and last bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v_reg <= '0;
            l_reg <= '0;
        end
        else begin
            v_reg <= {v_reg[5:0], valid_in};
            l_reg <= {l_reg[5:0], last_in};
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        sp_reg[0] <= sp_next;
        for (int i = 1; i < 7; i++) begin
            sp_reg[i] <= sp_reg[i-1];
        end
        be_reg[0] <= be_next;
        for (int i = 1; i < 5; i++) begin
            be_reg[i] <= be_reg[i-1];
        end
        zs_reg   <= {zs_reg[5:0], zs_next};
        sub_reg  <= {sub_reg[5:0], sub_next};
        bm1_reg  <= bm_next;
        sm1_reg  <= sm_next;
        d1_reg   <= d_next;
        big2_reg <= {bm1_reg, 3'd0};
        sml2_reg <= sml2_next;
        s3_reg   <= sub_reg[1] ? (57'(big2_reg) - 57'(sml2_reg))
                               : (57'(big2_reg) + 57'(sml2_reg));
        s4_reg   <= s3_reg;
        lz4_reg  <= fpc_pkg::lzc64({s3_reg[55:0], 8'd0});
        r5_reg   <= r5_next;
        z5_reg   <= (s4_reg == 57'd0);
        r6_reg   <= fpc_pkg::denorm(r5_reg);
        z6_reg   <= z5_reg;
        out7_reg <= out7_next;
    end

    assign valid_out = v_reg[6];
    assign last_out  = l_reg[6];
    assign sum_bits  = out7_reg;

endmodule

// ===== hdl/fpc_clamp.sv =====
`timescale 1ns / 1ps
// Two-stage clamp: upper bound (min), then lower bound (max), NaN ignoring.
// Depends on fpc_pkg for NaN detection and the canonical NaN.
module fpc_clamp
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid_in,
    input  logic        last_in,
    input  logic [63:0] val,
    input  logic [63:0] lower,
    input  logic [63:0] upper,
    output logic        valid_out,
    output logic        last_out,
    output logic [63:0] result
);

    logic [1:0]  v_reg;
    logic [1:0]  l_reg;
    logic [63:0] c1_reg, c1_next;
    logic [63:0] c2_reg, c2_next;

    // Ordered less-than on non-NaN values, zeros compare equal
    function automatic logic fp_less(input logic [63:0] x, input logic [63:0] y);
        if ((x[62:0] == 63'd0) && (y[62:0] == 63'd0)) return 1'b0;
        if (x[63] != y[63]) return x[63];
        if (!x[63]) return x[62:0] < y[62:0];
        return x[62:0] > y[62:0];
    endfunction

    // Apply the upper bound; a tie keeps the computed value
    always_comb
    begin
        logic nb, nv;
        nb = fpc_pkg::is_nan(upper);
        nv = fpc_pkg::is_nan(val);
        if (nb && nv) c1_next = fpc_pkg::QNAN;
        else if (nb) c1_next = val;
        else if (nv) c1_next = upper;
        else c1_next = fp_less(upper, val) ? upper : val;
    end

    // Apply the lower bound last so it wins over the upper
    always_comb
    begin
        logic nb, nv;
        nb = fpc_pkg::is_nan(lower);
        nv = fpc_pkg::is_nan(c1_reg);
        if (nb && nv) c2_next = fpc_pkg::QNAN;
        else if (nb) c2_next = c1_reg;
        else if (nv) c2_next = lower;
        else c2_next = fp_less(c1_reg, lower) ? lower : c1_reg;
    end

    // Advance the valid and last bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v_reg <= '0;
            l_reg <= '0;
        end
        else begin
            v_reg <= {v_reg[0], valid_in};
            l_reg <= {l_reg[0], last_in};
        end
    end

    // Hold the clamped values
    always_ff @(posedge clk)
    begin
        c1_reg <= c1_next;
        c2_reg <= c2_next;
    end

    assign valid_out = v_reg[1];
    assign last_out  = l_reg[1];
    assign result    = c2_reg;

endmodule

// ===== hdl/fpc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks on the affine clamp: fixed latency, flag transport and
// canonical NaN results. Depends on fpc_pkg; bound to fp64_affine_clamp.
module fpc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        last_in,
    input logic        done,
    input logic [63:0] result_bits,
    input logic        last_out
);

    // Every result comes from an item taken a fixed number of cycles before
    a_done_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, fpc_pkg::LATENCY))
        else $error("result without a matching item");

    // Every taken item produces a result after the fixed latency
    a_start_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(fpc_pkg::LATENCY) done)
        else $error("item lost in the pipeline");

    // The last flag travels with its item
    a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (last_out == $past(last_in, fpc_pkg::LATENCY)))
        else $error("last flag out of step");

    // Only the canonical NaN leaves the block
    a_canon_nan: assert property (@(posedge clk) disable iff (!rst_n)
        (done && fpc_pkg::is_nan(result_bits)) |-> (result_bits == fpc_pkg::QNAN))
        else $error("non-canonical NaN result");

endmodule

bind fp64_affine_clamp fpc_checker u_fpc_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .last_in     (last_in),
    .done        (done),
    .result_bits (result_bits),
    .last_out    (last_out)
);
